// ----- src/bdar_pkg.sv -----
`default_nettype none

package bdar_pkg;

    localparam int DIGIT_W   = 4;
    localparam int PAIR_W    = 2 * DIGIT_W;
    localparam int POS_W     = 9;
    localparam int ADDR_W    = POS_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CNT_W     = 10;

    localparam logic [CNT_W-1:0]   TOP_COUNT   = CNT_W'(2 ** POS_W + 1);
    localparam logic [DIGIT_W-1:0] MAX_DIGIT   = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] ROUND_LIMIT = DIGIT_W'(4);
    localparam logic [DIGIT_W:0]   RADIX       = (DIGIT_W + 1)'(10);

    localparam logic PART_INT  = 1'b0;
    localparam logic PART_FRAC = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR_INIT,
        DP_CLR_STEP,
        DP_LOAD,
        DP_READ_SUM,
        DP_OUT_READ,
        DP_OUT_ADD,
        DP_ADD_INIT,
        DP_ADD_RD,
        DP_ADD_WR,
        DP_CHK_RD,
        DP_CHK_EVAL,
        DP_ZERO_STEP,
        DP_RIP_INIT,
        DP_RIP_RD,
        DP_RIP_WR
    } t_dp_op;

    typedef struct packed {
        logic int_end;
        logic frac_end;
        logic carry;
        logic rip_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- src/bdar_ram.sv -----
`default_nettype none

module bdar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/bdar_datapath.sv -----
`default_nettype none

module bdar_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bdar_pkg::t_dp_op                  i_op,
    input  wire logic                              i_cfg_we,
    input  wire logic [bdar_pkg::POS_W-1:0]        i_cfg_data,
    input  wire logic                              i_part,
    input  wire logic [bdar_pkg::POS_W-1:0]        i_position,
    input  wire logic [bdar_pkg::DIGIT_W-1:0]      i_a_digit,
    input  wire logic [bdar_pkg::DIGIT_W-1:0]      i_b_digit,
    output bdar_pkg::t_dp_status                   o_status,
    output logic      [bdar_pkg::DIGIT_W-1:0]      o_digit,
    output logic      [bdar_pkg::CNT_W-1:0]        o_significant_int_digits
);

    logic [bdar_pkg::ADDR_W-1:0]  r_idx, n_idx;
    logic                         r_carry, n_carry;
    logic [bdar_pkg::CNT_W-1:0]   r_count, n_count;
    logic [bdar_pkg::POS_W-1:0]   r_round_places;
    logic [bdar_pkg::DIGIT_W-1:0] r_out_digit, n_out_digit;
    logic [bdar_pkg::CNT_W-1:0]   r_out_count, n_out_count;

    logic                         opnd_we, opnd_re;
    logic [bdar_pkg::ADDR_W-1:0]  opnd_waddr;
    logic [bdar_pkg::PAIR_W-1:0]  opnd_wdata, opnd_rdata;
    logic                         sum_we, sum_re;
    logic [bdar_pkg::ADDR_W-1:0]  sum_waddr, sum_raddr;
    logic [bdar_pkg::DIGIT_W-1:0] sum_wdata, sum_rdata;

    logic [bdar_pkg::POS_W-1:0]   idx_pos;
    logic                         idx_frac;
    logic [bdar_pkg::ADDR_W-1:0]  idx_step;
    logic [bdar_pkg::ADDR_W-1:0]  chk_addr;
    logic [bdar_pkg::DIGIT_W:0]   add_sum;
    logic                         add_ge;
    logic [bdar_pkg::DIGIT_W-1:0] add_digit, rip_digit;
    logic [bdar_pkg::DIGIT_W-1:0] sat_a, sat_b;
    logic [bdar_pkg::CNT_W-1:0]   pos_plus;
    logic                         at_int_end, at_frac_end;

    assign idx_pos  = r_idx[bdar_pkg::POS_W-1:0];
    assign idx_frac = r_idx[bdar_pkg::POS_W];
    assign chk_addr = {bdar_pkg::PART_FRAC, r_round_places};

    // Fraction digits walk toward the point, then the integer part walks upward.
    always_comb begin
        if (idx_frac == bdar_pkg::PART_FRAC) begin
            if (idx_pos == '0) begin
                idx_step = {bdar_pkg::PART_INT, {bdar_pkg::POS_W{1'b0}}};
            end else begin
                idx_step = r_idx - bdar_pkg::ADDR_W'(1);
            end
        end else begin
            idx_step = r_idx + bdar_pkg::ADDR_W'(1);
        end
    end

    assign add_sum   = {1'b0, opnd_rdata[bdar_pkg::PAIR_W-1:bdar_pkg::DIGIT_W]}
                     + {1'b0, opnd_rdata[bdar_pkg::DIGIT_W-1:0]}
                     + {{bdar_pkg::DIGIT_W{1'b0}}, r_carry};
    assign add_ge    = (add_sum >= bdar_pkg::RADIX);
    assign add_digit = add_ge ? bdar_pkg::DIGIT_W'(add_sum - bdar_pkg::RADIX)
                              : add_sum[bdar_pkg::DIGIT_W-1:0];
    assign rip_digit = (sum_rdata == bdar_pkg::MAX_DIGIT) ? '0
                     : sum_rdata + bdar_pkg::DIGIT_W'(1);
    assign sat_a     = (i_a_digit > bdar_pkg::MAX_DIGIT) ? bdar_pkg::MAX_DIGIT : i_a_digit;
    assign sat_b     = (i_b_digit > bdar_pkg::MAX_DIGIT) ? bdar_pkg::MAX_DIGIT : i_b_digit;
    assign pos_plus  = bdar_pkg::CNT_W'(idx_pos) + bdar_pkg::CNT_W'(1);

    assign at_int_end  = (r_idx == {bdar_pkg::PART_INT, {bdar_pkg::POS_W{1'b1}}});
    assign at_frac_end = (r_idx == {bdar_pkg::PART_FRAC, {bdar_pkg::POS_W{1'b1}}});

    always_comb begin
        n_idx       = r_idx;
        n_carry     = r_carry;
        n_count     = r_count;
        n_out_digit = r_out_digit;
        n_out_count = r_out_count;
        opnd_we     = 1'b0;
        opnd_waddr  = r_idx;
        opnd_wdata  = '0;
        opnd_re     = 1'b0;
        sum_we      = 1'b0;
        sum_waddr   = r_idx;
        sum_wdata   = '0;
        sum_re      = 1'b0;
        sum_raddr   = r_idx;
        unique case (i_op)
            bdar_pkg::DP_NOP: begin
            end
            bdar_pkg::DP_CLR_INIT: begin
                n_idx   = '0;
                n_count = '0;
            end
            bdar_pkg::DP_CLR_STEP: begin
                opnd_we = 1'b1;
                sum_we  = 1'b1;
                n_idx   = r_idx + bdar_pkg::ADDR_W'(1);
            end
            bdar_pkg::DP_LOAD: begin
                opnd_we    = 1'b1;
                opnd_waddr = {i_part, i_position};
                opnd_wdata = {sat_a, sat_b};
            end
            bdar_pkg::DP_READ_SUM: begin
                sum_re    = 1'b1;
                sum_raddr = {i_part, i_position};
            end
            bdar_pkg::DP_OUT_READ: begin
                n_out_digit = sum_rdata;
                n_out_count = r_count;
            end
            bdar_pkg::DP_OUT_ADD: begin
                n_out_digit = '0;
                n_out_count = r_count;
            end
            bdar_pkg::DP_ADD_INIT: begin
                n_idx   = {bdar_pkg::PART_FRAC, {bdar_pkg::POS_W{1'b1}}};
                n_carry = 1'b0;
                n_count = '0;
            end
            bdar_pkg::DP_ADD_RD: begin
                opnd_re = 1'b1;
            end
            bdar_pkg::DP_ADD_WR: begin
                sum_we    = 1'b1;
                sum_wdata = add_digit;
                n_carry   = add_ge;
                n_idx     = idx_step;
                if (idx_frac == bdar_pkg::PART_INT && add_digit != '0) begin
                    n_count = pos_plus;
                end
                if (at_int_end && add_ge) begin
                    n_count = bdar_pkg::TOP_COUNT;
                end
            end
            bdar_pkg::DP_CHK_RD: begin
                sum_re    = 1'b1;
                sum_raddr = chk_addr;
            end
            bdar_pkg::DP_CHK_EVAL: begin
                n_carry = (sum_rdata > bdar_pkg::ROUND_LIMIT);
                n_idx   = chk_addr;
            end
            bdar_pkg::DP_ZERO_STEP: begin
                sum_we = 1'b1;
                n_idx  = r_idx + bdar_pkg::ADDR_W'(1);
            end
            bdar_pkg::DP_RIP_INIT: begin
                if (r_round_places == '0) begin
                    n_idx = {bdar_pkg::PART_INT, {bdar_pkg::POS_W{1'b0}}};
                end else begin
                    n_idx = {bdar_pkg::PART_FRAC,
                             r_round_places - bdar_pkg::POS_W'(1)};
                end
            end
            bdar_pkg::DP_RIP_RD: begin
                sum_re = 1'b1;
            end
            bdar_pkg::DP_RIP_WR: begin
                sum_we    = 1'b1;
                sum_wdata = rip_digit;
                n_carry   = (sum_rdata == bdar_pkg::MAX_DIGIT);
                n_idx     = idx_step;
                if (idx_frac == bdar_pkg::PART_INT && rip_digit != '0
                        && pos_plus > r_count) begin
                    n_count = pos_plus;
                end
                if (at_int_end && sum_rdata == bdar_pkg::MAX_DIGIT) begin
                    n_count = bdar_pkg::TOP_COUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx          <= '0;
            r_carry        <= 1'b0;
            r_count        <= '0;
            r_round_places <= '0;
        end else begin
            r_idx   <= n_idx;
            r_carry <= n_carry;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_round_places <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_digit <= n_out_digit;
        r_out_count <= n_out_count;
    end

    bdar_ram #(
        .WIDTH (bdar_pkg::PAIR_W),
        .DEPTH (bdar_pkg::MEM_DEPTH)
    ) u_opnd_ram (
        .i_clk   (i_clk),
        .i_we    (opnd_we),
        .i_waddr (opnd_waddr),
        .i_wdata (opnd_wdata),
        .i_re    (opnd_re),
        .i_raddr (r_idx),
        .o_rdata (opnd_rdata)
    );

    bdar_ram #(
        .WIDTH (bdar_pkg::DIGIT_W),
        .DEPTH (bdar_pkg::MEM_DEPTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    assign o_status.int_end  = at_int_end;
    assign o_status.frac_end = at_frac_end;
    assign o_status.carry    = r_carry;
    assign o_status.rip_done = (sum_rdata != bdar_pkg::MAX_DIGIT) || at_int_end;

    assign o_digit                  = r_out_digit;
    assign o_significant_int_digits = r_out_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdar_pkg::TOP_COUNT)
        else $error("significant digit count above its limit");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == bdar_pkg::DP_CHK_EVAL) |=> (r_idx[bdar_pkg::POS_W] == bdar_pkg::PART_FRAC))
        else $error("zero sweep does not start in the fraction part");
`endif

endmodule

`default_nettype wire

// ----- src/bdar_ctrl.sv -----
`default_nettype none

module bdar_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [1:0]           i_command,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire bdar_pkg::t_dp_status i_status,
    output bdar_pkg::t_dp_op          o_op
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_ZERO,
        ST_RIP_INIT,
        ST_RIP_RD,
        ST_RIP_WR,
        ST_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;
    logic   load_out;

    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        o_op     = bdar_pkg::DP_NOP;
        load_out = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_op = bdar_pkg::DP_CLR_STEP;
                if (i_status.frac_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        bdar_pkg::CMD_CLEAR: begin
                            o_op    = bdar_pkg::DP_CLR_INIT;
                            n_state = ST_CLEAR;
                        end
                        bdar_pkg::CMD_LOAD: begin
                            o_op = bdar_pkg::DP_LOAD;
                        end
                        bdar_pkg::CMD_ADD: begin
                            o_op    = bdar_pkg::DP_ADD_INIT;
                            n_state = ST_ADD_RD;
                        end
                        bdar_pkg::CMD_READ: begin
                            o_op    = bdar_pkg::DP_READ_SUM;
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (can_load) begin
                    o_op     = bdar_pkg::DP_OUT_READ;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_ADD_RD: begin
                o_op    = bdar_pkg::DP_ADD_RD;
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                o_op    = bdar_pkg::DP_ADD_WR;
                n_state = i_status.int_end ? ST_CHK_RD : ST_ADD_RD;
            end
            ST_CHK_RD: begin
                o_op    = bdar_pkg::DP_CHK_RD;
                n_state = ST_CHK_EVAL;
            end
            ST_CHK_EVAL: begin
                o_op    = bdar_pkg::DP_CHK_EVAL;
                n_state = ST_ZERO;
            end
            ST_ZERO: begin
                o_op = bdar_pkg::DP_ZERO_STEP;
                if (i_status.frac_end) begin
                    n_state = ST_RIP_INIT;
                end
            end
            ST_RIP_INIT: begin
                o_op    = bdar_pkg::DP_RIP_INIT;
                n_state = i_status.carry ? ST_RIP_RD : ST_RESULT;
            end
            ST_RIP_RD: begin
                o_op    = bdar_pkg::DP_RIP_RD;
                n_state = ST_RIP_WR;
            end
            ST_RIP_WR: begin
                o_op    = bdar_pkg::DP_RIP_WR;
                n_state = i_status.rip_done ? ST_RESULT : ST_RIP_RD;
            end
            ST_RESULT: begin
                if (can_load) begin
                    o_op     = bdar_pkg::DP_OUT_ADD;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_READ || $past(r_state) == ST_RESULT))
        else $error("result word raised outside a result state");

    a_add_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == bdar_pkg::CMD_ADD) |=> (r_state == ST_ADD_RD))
        else $error("add command did not start the digit walk");

    a_ripple_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RIP_WR && i_status.rip_done) |=> (r_state == ST_RESULT))
        else $error("rounding carry walk did not end in the result state");
`endif

endmodule

`default_nettype wire

// ----- src/bcd_decimal_add_round_unit.sv -----
// Channel  Valid        Stall        Payload
// input    i_in_valid   o_in_stall   i_command, i_part, i_position, i_a_digit, i_b_digit
// output   o_out_valid  i_out_stall  o_digit, o_significant_int_digits
// config   i_cfg_we     (none)       i_cfg_data
//
// A load writes the operand RAM and gives no result word; a read passes its digit through
// the sum RAM read register and the output register. A clear zeroes both digit RAMs, and
// after reset the same clearing pass runs first. An add reads, then writes each digit over
// each RAM's single read port, then zeroes the rounded-off digits and ripples any carry.
// New words are taken only while the controller is idle; a held result word stays
// in the output register while the next word is accepted.
`default_nettype none

module bcd_decimal_add_round_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic                          i_part,
    input  wire logic [bdar_pkg::POS_W-1:0]    i_position,
    input  wire logic [bdar_pkg::DIGIT_W-1:0]  i_a_digit,
    input  wire logic [bdar_pkg::DIGIT_W-1:0]  i_b_digit,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [bdar_pkg::DIGIT_W-1:0]  o_digit,
    output logic      [bdar_pkg::CNT_W-1:0]    o_significant_int_digits,
    input  wire logic                          i_cfg_we,
    input  wire logic [bdar_pkg::POS_W-1:0]    i_cfg_data
);

    bdar_pkg::t_dp_op     op;
    bdar_pkg::t_dp_status status;

    bdar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_op        (op)
    );

    bdar_datapath u_datapath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_op                     (op),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_data               (i_cfg_data),
        .i_part                   (i_part),
        .i_position               (i_position),
        .i_a_digit                (i_a_digit),
        .i_b_digit                (i_b_digit),
        .o_status                 (status),
        .o_digit                  (o_digit),
        .o_significant_int_digits (o_significant_int_digits)
    );

endmodule

`default_nettype wire
